### hw/rtl/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared types and constants of the stereo tilt equalizer: word formats,
// register indexes, lane operations, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TAP_W      = 7;
    localparam int SLANT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = SAMPLE_W + 2;
    localparam int STEP_CNT_W = $clog2(QUO_W);

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLANT     = 2'd1;

    localparam logic [TAP_W-1:0]   TAP_RESET   = 7'd1;
    localparam logic [SLANT_W-1:0] SLANT_RESET = 16'h8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_word;

    typedef enum logic [2:0] {
        LOP_HOLD,
        LOP_MAC_FIRST,
        LOP_MAC,
        LOP_PREP,
        LOP_MUL,
        LOP_DIV_INIT,
        LOP_DIV,
        LOP_FIN
    } t_lane_op;

    typedef enum logic [1:0] {
        WSEL_ZERO,
        WSEL_SHIFT,
        WSEL_SAMPLE
    } t_wsel;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT,
        ST_WR0,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_seq_state;

    typedef struct packed {
        t_lane_op op;
        logic     sel_hist;
        logic     mem_we;
        t_wsel    wsel;
        logic     mem_re;
        logic     out_load;
        logic     in_ready;
    } t_seq_ctl;

endpackage

### hw/rtl/tfe_hist_mem.sv
// ----------------------------------------------------------------------------
// tfe_hist_mem
// Stereo sample history: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tfe_hist_mem #(
    parameter int DEPTH  = 101,
    parameter int DATA_W = 48,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tfe_lane.sv
// ----------------------------------------------------------------------------
// tfe_lane
// One channel's arithmetic: multiply-accumulate of the weighted window,
// shift-add scaling by slant, restoring divide by N^2 with rounding,
// then add to the sample and saturate.
// ----------------------------------------------------------------------------
module tfe_lane import tfe_pkg::*; #(
    parameter int MAX_TAPS = 100,
    localparam int NW      = $clog2(MAX_TAPS + 1),
    localparam int WB      = 2 * NW + 1
) (
    input  logic                       i_clk,
    input  t_lane_op                   i_op,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [WB-1:0]       i_weight,
    input  logic [2*NW-1:0]            i_den,
    input  logic signed [SLANT_W-1:0]  i_slant,
    output logic signed [SAMPLE_W-1:0] o_y
);

    localparam int CW = SAMPLE_W + 2 * NW + 2;
    localparam int PW = CW + SLANT_W - 1;
    localparam int DW = PW + 1 - (SLANT_W - 1);
    localparam int RW = 2 * NW + 1;
    localparam int YW = QUO_W + 2;
    localparam logic signed [YW-1:0] Y_HI = YW'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [YW-1:0] Y_LO = -Y_HI - YW'(1);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [CW-1:0]       r_acc;
    logic [CW-1:0]              r_mc;
    logic [SLANT_W-1:0]         r_sm;
    logic                       r_neg;
    logic [PW-1:0]              r_prod;
    logic [RW-1:0]              r_rem;
    logic [QUO_W-1:0]           r_dq;
    logic signed [SAMPLE_W-1:0] r_y;

    logic signed [SAMPLE_W+WB-1:0] mac_p;
    logic [PW:0]                   num;
    logic [DW-1:0]                 dvd;
    logic [RW:0]                   trial;
    logic                          fits;
    logic signed [YW-1:0]          y_sum;

    assign mac_p = i_sample * i_weight;
    assign num   = {1'b0, r_prod} + ((PW + 1)'(i_den) << (SLANT_W - 2));
    assign dvd   = num[PW:SLANT_W-1];
    assign trial = {r_rem, r_dq[QUO_W-1]};
    assign fits  = (trial >= (RW + 1)'(i_den));
    assign y_sum = r_neg ? (YW'(r_x) - $signed({2'b00, r_dq}))
                         : (YW'(r_x) + $signed({2'b00, r_dq}));

    always_ff @(posedge i_clk) begin
        case (i_op)
            LOP_MAC_FIRST: begin
                r_x   <= i_sample;
                r_acc <= CW'(mac_p);
            end
            LOP_MAC: begin
                r_acc <= r_acc + CW'(mac_p);
            end
            LOP_PREP: begin
                r_mc   <= r_acc[CW-1] ? -r_acc : r_acc;
                r_sm   <= i_slant[SLANT_W-1] ? -i_slant : i_slant;
                r_neg  <= r_acc[CW-1] ^ i_slant[SLANT_W-1];
                r_prod <= '0;
            end
            LOP_MUL: begin
                r_prod <= {r_prod[PW-2:0], 1'b0} + (r_sm[SLANT_W-1] ? PW'(r_mc) : '0);
                r_sm   <= {r_sm[SLANT_W-2:0], 1'b0};
            end
            LOP_DIV_INIT: begin
                r_rem <= dvd[DW-1:QUO_W];
                r_dq  <= dvd[QUO_W-1:0];
            end
            LOP_DIV: begin
                r_rem <= fits ? RW'(trial - (RW + 1)'(i_den)) : trial[RW-1:0];
                r_dq  <= {r_dq[QUO_W-2:0], fits};
            end
            LOP_FIN: begin
                if (y_sum > Y_HI) begin
                    r_y <= Y_HI[SAMPLE_W-1:0];
                end else if (y_sum < Y_LO) begin
                    r_y <= Y_LO[SAMPLE_W-1:0];
                end else begin
                    r_y <= y_sum[SAMPLE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_y = r_y;

endmodule

### hw/rtl/tfe_seq.sv
// ----------------------------------------------------------------------------
// tfe_seq
// Sequencer: history clearing sweep, shift and accumulate pass through the
// memory, multiply and divide step counts, result hand-off.
// ----------------------------------------------------------------------------
module tfe_seq import tfe_pkg::*; #(
    parameter int MAX_TAPS = 100,
    localparam int NW      = $clog2(MAX_TAPS + 1),
    localparam int WB      = 2 * NW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_free,
    input  logic [TAP_W-1:0]     i_tap,
    input  logic                 i_tap_we,
    input  logic [TAP_W-1:0]     i_tap_wdata,
    output t_seq_ctl             o_ctl,
    output logic [NW-1:0]        o_waddr,
    output logic [NW-1:0]        o_raddr,
    output logic signed [WB-1:0] o_weight,
    output logic [2*NW-1:0]      o_den
);

    localparam int CMP_W = ((NW > TAP_W) ? NW : TAP_W) + 1;

    t_seq_state              r_state, n_state;
    logic [NW-1:0]           r_n;
    logic [2*NW-1:0]         r_n2;
    logic [NW-1:0]           r_cur, n_cur;
    logic [NW-1:0]           r_lo, n_lo;
    logic [STEP_CNT_W-1:0]   r_cnt, n_cnt;

    logic [NW-1:0]           win_cur;
    logic [NW-1:0]           win_new;
    logic [NW-1:0]           lo_next;
    logic [NW-1:0]           rd_first;
    logic [NW:0]             jp1;
    logic [NW-1:0]           span;
    logic signed [WB-1:0]    w_first;
    logic signed [WB-1:0]    w_hist;

    function automatic logic [NW-1:0] f_window(input logic [TAP_W-1:0] tap);
        logic [CMP_W-1:0] t;
        begin
            t = CMP_W'(tap);
            if (t == '0) begin
                return NW'(1);
            end else if (t > CMP_W'(MAX_TAPS)) begin
                return NW'(MAX_TAPS);
            end else begin
                return NW'(t);
            end
        end
    endfunction

    assign win_cur  = f_window(i_tap);
    assign win_new  = f_window(i_tap_wdata);
    assign lo_next  = (i_tap_we && (win_new < r_lo)) ? win_new : r_lo;
    assign rd_first = (r_n == NW'(MAX_TAPS)) ? NW'(MAX_TAPS - 1) : r_n;
    assign jp1      = {1'b0, r_cur} + (NW + 1)'(1);
    assign span     = r_n - r_cur - NW'(1);
    assign w_first  = $signed({1'b0, r_n2}) - $signed({{NW{1'b0}}, r_n, 1'b0});
    assign w_hist   = (jp1 < {1'b0, r_n}) ? -$signed({{NW{1'b0}}, span, 1'b0}) : '0;
    assign o_den    = r_n2;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cur <= lo_next) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_tap_we) begin
                    n_state = ST_CLEAR;
                end else if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_cur == '0) begin
                    n_state = ST_WR0;
                end
            end
            ST_WR0: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == STEP_CNT_W'(SLANT_W - 1)) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == STEP_CNT_W'(QUO_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl          = '0;
        o_ctl.op       = LOP_HOLD;
        o_ctl.wsel     = WSEL_ZERO;
        o_waddr        = r_cur;
        o_raddr        = r_cur;
        o_weight       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_ctl.in_ready = !i_tap_we;
            end
            ST_LOAD: begin
                o_ctl.op     = LOP_MAC_FIRST;
                o_ctl.mem_re = 1'b1;
                o_raddr      = rd_first;
                o_weight     = w_first;
            end
            ST_SHIFT: begin
                o_ctl.op       = LOP_MAC;
                o_ctl.sel_hist = 1'b1;
                o_ctl.mem_we   = 1'b1;
                o_ctl.wsel     = WSEL_SHIFT;
                o_ctl.mem_re   = (r_cur != '0);
                o_waddr        = r_cur + NW'(1);
                o_raddr        = r_cur - NW'(1);
                o_weight       = w_hist;
            end
            ST_WR0: begin
                o_ctl.op     = LOP_PREP;
                o_ctl.mem_we = 1'b1;
                o_ctl.wsel   = WSEL_SAMPLE;
                o_waddr      = '0;
            end
            ST_MUL: begin
                o_ctl.op = LOP_MUL;
            end
            ST_DIV_INIT: begin
                o_ctl.op = LOP_DIV_INIT;
            end
            ST_DIV: begin
                o_ctl.op = LOP_DIV;
            end
            ST_FIN: begin
                o_ctl.op = LOP_FIN;
            end
            ST_DONE: begin
                o_ctl.out_load = i_out_free;
            end
            default: begin
            end
        endcase
    end

    // counters and pointers
    always_comb begin
        n_cur = r_cur;
        n_lo  = r_lo;
        n_cnt = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_lo = lo_next;
                if (r_cur > lo_next) begin
                    n_cur = r_cur - NW'(1);
                end
            end
            ST_IDLE: begin
                if (i_tap_we) begin
                    n_cur = NW'(MAX_TAPS);
                    n_lo  = win_new;
                end
            end
            ST_LOAD: begin
                n_cur = rd_first;
            end
            ST_SHIFT: begin
                if (r_cur != '0) begin
                    n_cur = r_cur - NW'(1);
                end
            end
            ST_WR0, ST_DIV_INIT: begin
                n_cnt = '0;
            end
            ST_MUL, ST_DIV: begin
                n_cnt = r_cnt + STEP_CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cur   <= NW'(MAX_TAPS);
            r_lo    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_lo    <= n_lo;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_n  <= win_cur;
            r_n2 <= (2 * NW)'(win_cur) * (2 * NW)'(win_cur);
        end
    end

endmodule

### hw/rtl/stereo_tilt_fir_equalizer_core.sv
// ----------------------------------------------------------------------------
// stereo_tilt_fir_equalizer_core
// Stereo tilt equalizer around a triangular-weighted FIR lowpass average.
//
//   channel  direction  handshake                 word
//   in       to core    i_in_valid / o_in_ready   t_in_word (left, right)
//   out      from core  o_out_valid / i_out_ready t_out_word (left, right)
//   cfg      to core    i_cfg_we, no wait         index + 16-bit data
//
// each word runs the history shift pass through the memory, then 16 shift-add
// and 26 divide steps, one word at a time; the next word is taken while the
// result waits
// after reset a clearing pass over all MAX_TAPS+1 entries holds o_in_ready low
// a tap_count write clears MAX_TAPS-N+1 entries with o_in_ready low
// a stalled output holds the finished word and blocks only the next result
// ----------------------------------------------------------------------------
module stereo_tilt_fir_equalizer_core import tfe_pkg::*; #(
    parameter int MAX_TAPS = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NW = $clog2(MAX_TAPS + 1);
    localparam int WB = 2 * NW + 1;

    logic [TAP_W-1:0]          r_tap;
    logic signed [SLANT_W-1:0] r_slant;
    t_in_word                  r_in;
    logic                      r_out_valid;
    t_out_word                 r_out;

    t_seq_ctl                  ctl;
    logic [NW-1:0]             waddr;
    logic [NW-1:0]             raddr;
    logic signed [WB-1:0]      weight;
    logic [2*NW-1:0]           den;
    t_in_word                  mem_rdata;
    t_in_word                  mem_wdata;
    logic                      tap_we;
    logic                      out_free;
    logic signed [SAMPLE_W-1:0] lane_in_l;
    logic signed [SAMPLE_W-1:0] lane_in_r;
    logic signed [SAMPLE_W-1:0] y_l;
    logic signed [SAMPLE_W-1:0] y_r;

    assign tap_we   = i_cfg_we && (i_cfg_idx == CFG_TAP_COUNT);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= TAP_RESET;
            r_slant <= SLANT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAP_COUNT: r_tap   <= i_cfg_wdata[TAP_W-1:0];
                CFG_SLANT:     r_slant <= i_cfg_wdata[SLANT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    tfe_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_free  (out_free),
        .i_tap       (r_tap),
        .i_tap_we    (tap_we),
        .i_tap_wdata (i_cfg_wdata[TAP_W-1:0]),
        .o_ctl       (ctl),
        .o_waddr     (waddr),
        .o_raddr     (raddr),
        .o_weight    (weight),
        .o_den       (den)
    );

    always_comb begin
        case (ctl.wsel)
            WSEL_SHIFT:  mem_wdata = mem_rdata;
            WSEL_SAMPLE: mem_wdata = r_in;
            default:     mem_wdata = '0;
        endcase
    end

    tfe_hist_mem #(.DEPTH(MAX_TAPS + 1), .DATA_W($bits(t_in_word))) u_mem (
        .i_clk   (i_clk),
        .i_we    (ctl.mem_we),
        .i_waddr (waddr),
        .i_wdata (mem_wdata),
        .i_re    (ctl.mem_re),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    assign lane_in_l = ctl.sel_hist ? mem_rdata.left_sample  : r_in.left_sample;
    assign lane_in_r = ctl.sel_hist ? mem_rdata.right_sample : r_in.right_sample;

    tfe_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_l (
        .i_clk    (i_clk),
        .i_op     (ctl.op),
        .i_sample (lane_in_l),
        .i_weight (weight),
        .i_den    (den),
        .i_slant  (r_slant),
        .o_y      (y_l)
    );

    tfe_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_r (
        .i_clk    (i_clk),
        .i_op     (ctl.op),
        .i_sample (lane_in_r),
        .i_weight (weight),
        .i_den    (den),
        .i_slant  (r_slant),
        .o_y      (y_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out.left_out  <= y_l;
            r_out.right_out <= y_r;
        end
    end

    assign o_in_ready  = ctl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/tfe_checker.sv
// ----------------------------------------------------------------------------
// tfe_checker
// Port-level checks of the tilt equalizer core, bound to the top level.
// ----------------------------------------------------------------------------
module tfe_checker import tfe_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_word            o_out_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx
);

    // reset starts the clearing pass with nothing on the output
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("core not quiet after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after a word was taken");

    a_tap_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_TAP_COUNT) |-> !o_in_ready)
        else $error("input taken during a tap_count write");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while core was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

endmodule

bind stereo_tilt_fir_equalizer_core tfe_checker u_tfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo tilt equalizer core. A scoreboard class
// keeps its own copy of both delay lines and of the two registers, predicts
// the tilted word for every word taken in and compares each delivered word
// field by field. Directed words cover the sample extremes, the tap count
// limits, unused register indexes and window shrink/widen; random phases
// mix noise, held levels and square waves under random idling, with one long
// output hold-off and a full drain before every register change.
// ----------------------------------------------------------------------------
module testbench;
    import tfe_pkg::*;

    localparam int     MAX_TAPS        = 100;
    localparam int     HIST_DEPTH      = MAX_TAPS + 1;
    localparam int     RANDOM_ITEMS    = 880;
    localparam int     HOLD_OFF_CYCLES = 700;
    localparam int     WATCHDOG_LIMIT  = 5000;
    localparam int     MAX_REPORTS     = 10;
    localparam longint SAMPLE_MAX      = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef enum int {
        RUN_NOISE,
        RUN_LEVEL,
        RUN_SQUARE
    } t_run_shape;

    class tilt_checker;
        logic [TAP_W-1:0]          tap_reg;
        logic signed [SLANT_W-1:0] slant_reg;
        longint                    history [2][HIST_DEPTH];
        t_out_word                 pending_words [$];
        int                        mismatch_count;

        function new();
            int c;
            int k;
            tap_reg        = TAP_RESET;
            slant_reg      = SLANT_RESET;
            mismatch_count = 0;
            for (c = 0; c < 2; c++) begin
                for (k = 0; k < HIST_DEPTH; k++) begin
                    history[c][k] = 0;
                end
            end
        endfunction

        function int window_len();
            int n;
            n = tap_reg;
            if (n < 1) begin
                return 1;
            end
            if (n > MAX_TAPS) begin
                return MAX_TAPS;
            end
            return n;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int k;
            if (idx == CFG_TAP_COUNT) begin
                tap_reg = data[TAP_W-1:0];
                // entries beyond the new window are blanked
                for (k = window_len(); k <= MAX_TAPS; k++) begin
                    history[0][k] = 0;
                    history[1][k] = 0;
                end
            end else if (idx == CFG_SLANT) begin
                slant_reg = data[SLANT_W-1:0];
            end
        endfunction

        function logic signed [SAMPLE_W-1:0] tilt(int ch, longint x);
            int     n;
            int     top;
            int     k;
            longint acc;
            longint n_sq;
            longint corr;
            longint s;
            longint mag;
            longint den;
            longint q;
            longint y;
            n   = window_len();
            top = (n + 1 > MAX_TAPS) ? MAX_TAPS : n + 1;
            for (k = top; k >= 1; k--) begin
                history[ch][k] = history[ch][k-1];
            end
            history[ch][0] = x;
            acc = 0;
            for (k = 0; k < n; k++) begin
                acc += history[ch][k] * (n - k);
            end
            n_sq = n * n;
            corr = x * n_sq - 2 * acc;
            s    = slant_reg;
            mag  = (corr < 0 ? -corr : corr) * (s < 0 ? -s : s);
            den  = 64'sd32768 * n_sq;
            // round to nearest, ties away from zero
            q    = (mag + den / 2) / den;
            y    = ((corr < 0) != (s < 0)) ? x - q : x + q;
            if (y > SAMPLE_MAX) begin
                y = SAMPLE_MAX;
            end
            if (y < SAMPLE_MIN) begin
                y = SAMPLE_MIN;
            end
            return y[SAMPLE_W-1:0];
        endfunction

        function void note_word(t_in_word w);
            t_out_word e;
            e.left_out  = tilt(0, w.left_sample);
            e.right_out = tilt(1, w.right_sample);
            pending_words.push_back(e);
        endfunction

        function void flag(string field, longint want, longint seen);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch at %0t: %s expected %0d got %0d", $time, field, want, seen);
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word e;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected word at %0t: left %0d right %0d",
                             $time, got.left_out, got.right_out);
                end
                return;
            end
            e = pending_words.pop_front();
            if (got.left_out !== e.left_out) begin
                flag("left_out", e.left_out, got.left_out);
            end
            if (got.right_out !== e.right_out) begin
                flag("right_out", e.right_out, got.right_out);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    logic quiet_in      = 1'b0;
    logic quiet_out     = 1'b0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;

    tilt_checker sb;

    stereo_tilt_fir_equalizer_core #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_word word_of(logic signed [SAMPLE_W-1:0] l,
                                         logic signed [SAMPLE_W-1:0] r);
        t_in_word w;
        w.left_sample  = l;
        w.right_sample = r;
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                return SAMPLE_W'($urandom);
            end
            3: begin
                return $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            4: begin
                return SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
            end
            default: begin
                return $urandom_range(0, 1) ? S_MAX - SAMPLE_W'($urandom_range(0, 255))
                                            : S_MIN + SAMPLE_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = quiet_in ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        // tap count write starts a clearing pass
        if (idx == CFG_TAP_COUNT) begin
            repeat (MAX_TAPS + 4) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_idx, i_cfg_wdata);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_word(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_word(o_out_data);
            end
        end
    end

    initial begin : receiver
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
                i_out_ready <= 1'b1;
            end else begin
                gap = quiet_out ? 0 : idle_len();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int                          sent;
        int                          phase;
        int                          count;
        int                          k;
        int                          run_left;
        t_run_shape                  run_shape;
        logic signed [SAMPLE_W-1:0]  run_l;
        logic signed [SAMPLE_W-1:0]  run_r;
        logic [TAP_W-1:0]            tap;
        logic [CFG_DATA_W-1:0]       tap_wdata;
        logic [CFG_DATA_W-1:0]       slant_wdata;
        t_in_word                    w;
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        run_left    = 0;
        run_shape   = RUN_NOISE;
        run_l       = '0;
        run_r       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one tap, full negative slant
        send_word(word_of(S_MAX, S_MIN));
        send_word(word_of(S_MIN, S_MAX));
        send_word(word_of('0, '0));
        send_word(word_of(24'sd1, -24'sd1));
        send_word(word_of(-24'sd1, 24'sd1));
        send_word(word_of(S_MAX, S_MAX));

        // tap count zero acts as one, unused indexes ignored
        wait_drained();
        write_reg(CFG_TAP_COUNT, 16'hFF80);
        write_reg(CFG_SLANT, 16'h7FFF);
        write_reg(CFG_UNUSED_A, 16'hFFFF);
        write_reg(CFG_UNUSED_B, 16'hFFFF);
        send_word(word_of(S_MAX, S_MIN));
        send_word(word_of(S_MIN, S_MAX));
        send_word(word_of(24'sd12345, -24'sd12345));

        // tap count above range clamps to the longest window
        wait_drained();
        write_reg(CFG_TAP_COUNT, 16'h007F);
        write_reg(CFG_SLANT, 16'h8000);
        for (k = 0; k < 5; k++) begin
            send_word(word_of(S_MAX, S_MIN));
        end
        send_word(word_of(S_MIN, S_MAX));
        send_word(word_of(S_MIN, S_MAX));
        send_word(word_of('0, '0));

        // shrink then widen: old tail must come back as zeros
        wait_drained();
        write_reg(CFG_TAP_COUNT, 16'd3);
        write_reg(CFG_SLANT, 16'h4000);
        send_word(word_of(S_MAX, S_MIN));
        send_word(word_of('0, '0));
        wait_drained();
        write_reg(CFG_TAP_COUNT, 16'd100);
        send_word(word_of(24'sd1, -24'sd1));
        send_word(word_of(24'sd1, -24'sd1));

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            case (phase)
                0:       tap = 7'd100;
                1:       tap = 7'd2;
                2:       tap = 7'd1;
                3:       tap = 7'd0;
                4:       tap = 7'd127;
                default: tap = ($urandom_range(0, 3) == 0) ? TAP_W'($urandom_range(0, 127))
                                                           : TAP_W'($urandom_range(1, 24));
            endcase
            if (phase < 5 || $urandom_range(0, 3) != 0) begin
                tap_wdata = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
                tap_wdata[TAP_W-1:0] = tap;
                write_reg(CFG_TAP_COUNT, tap_wdata);
            end
            case (phase % 5)
                0:       slant_wdata = 16'h8000;
                1:       slant_wdata = 16'h7FFF;
                2:       slant_wdata = 16'h0000;
                default: slant_wdata = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_SLANT, slant_wdata);
            quiet_in  <= ($urandom_range(0, 3) == 0);
            quiet_out <= ($urandom_range(0, 3) == 0);
            // long output stall while input keeps coming
            if (phase == 2) begin
                hold_off_req <= 1'b1;
            end
            count = $urandom_range(40, 110);
            for (k = 0; k < count; k++) begin
                if (run_left == 0) begin
                    run_left  = $urandom_range(1, 48);
                    run_shape = t_run_shape'($urandom_range(0, 2));
                    run_l     = draw_sample();
                    run_r     = draw_sample();
                end
                run_left--;
                case (run_shape)
                    RUN_LEVEL: begin
                        w = word_of(run_l, run_r);
                    end
                    RUN_SQUARE: begin
                        run_l = -run_l;
                        run_r = -run_r;
                        w     = word_of(run_l, run_r);
                    end
                    default: begin
                        w = word_of(draw_sample(), draw_sample());
                    end
                endcase
                send_word(w);
            end
            sent += count;
            phase++;
        end

        wait_drained();
        repeat (MAX_TAPS + 60) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
